// File: rtl/sors_pkg.sv
// ----------------------------------------------------------------------------
// sors_pkg
// Shared types and constants of the staggered output rise sequencer: command
// codes, register indexes, lane geometry and the transaction payloads.
// ----------------------------------------------------------------------------
package sors_pkg;

   // channel geometry
   localparam int NUM_CHANNELS_DEFAULT = 64;
   localparam int LANE_W               = 8;
   localparam int LANE_IDX_W           = 3;
   localparam int STATION_W            = 6;
   localparam int MAP_W                = 64;
   localparam int TIME_W               = 32;

   // configuration registers
   localparam int ACT_W       = 7;
   localparam int STAGGER_W   = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_STATIONS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGGER_MS      = 1'd1;
   localparam logic [ACT_W-1:0]     ACTIVE_RESET        = 7'd64;
   localparam logic [STAGGER_W-1:0] STAGGER_RESET       = 16'd250;

   // command codes
   typedef enum logic [1:0] {
      CMD_ADVANCE      = 2'd0,
      CMD_RISE_DONE    = 2'd1,
      CMD_CLEAR_TIMING = 2'd2
   } cmd_type;

   // request transaction
   typedef struct packed {
      cmd_type             cmd;
      logic [MAP_W-1:0]    desired_bits;
      logic [MAP_W-1:0]    priority_bits;
      logic [TIME_W-1:0]   now_ms;
      logic                rise_enable;
   } req_payload_type;

   // response transaction
   typedef struct packed {
      logic                 changed;
      logic                 rise_valid;
      logic [STATION_W-1:0] rising_station;
      logic [MAP_W-1:0]     applied_out;
   } rsp_payload_type;

   // what one lane found
   typedef struct packed {
      logic                  fall_any;
      logic                  pri_hit;
      logic [LANE_IDX_W-1:0] pri_idx;
      logic                  pend_hit;
      logic [LANE_IDX_W-1:0] pend_idx;
   } lane_res_type;

   // merged decision
   typedef struct packed {
      logic                 fall_any;
      logic                 rise;
      logic [STATION_W-1:0] station;
   } merge_res_type;

endpackage

// File: rtl/sors_stream_if.sv
// ----------------------------------------------------------------------------
// sors_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface sors_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/sors_lane.sv
// ----------------------------------------------------------------------------
// sors_lane
// One slice of channels: clears unwanted outputs and finds the lowest pending
// priority channel and the lowest pending channel of the slice.
// ----------------------------------------------------------------------------
module sors_lane
   import sors_pkg::*;
(
   input  logic [LANE_W-1:0] applied_bits,
   input  logic [LANE_W-1:0] desired_bits,
   input  logic [LANE_W-1:0] priority_bits,
   input  logic [LANE_W-1:0] used_mask,
   output logic [LANE_W-1:0] kept_bits,
   output lane_res_type      lane_res
);

   logic [LANE_W-1:0] fall;
   logic [LANE_W-1:0] pend;
   logic [LANE_W-1:0] pend_pri;

   // falls and pending rises
   assign fall      = applied_bits & ~desired_bits & used_mask;
   assign kept_bits = applied_bits & ~fall;
   assign pend      = desired_bits & ~applied_bits & used_mask;
   assign pend_pri  = pend & priority_bits;

   // lowest set bit of each candidate set
   always_comb begin
      lane_res          = '0;
      lane_res.fall_any = |fall;
      lane_res.pri_hit  = |pend_pri;
      lane_res.pend_hit = |pend;
      for (int i = LANE_W - 1; i >= 0; i--) begin
         if (pend_pri[i]) begin
            lane_res.pri_idx = LANE_IDX_W'(i);
         end
         if (pend[i]) begin
            lane_res.pend_idx = LANE_IDX_W'(i);
         end
      end
   end

endmodule

// File: rtl/sors_merge.sv
// ----------------------------------------------------------------------------
// sors_merge
// Combines the lane results: any fall, and the single channel to raise
// (lowest priority hit over all lanes, else lowest pending hit).
// ----------------------------------------------------------------------------
module sors_merge
   import sors_pkg::*;
#(
   parameter int NUM_LANES = NUM_CHANNELS_DEFAULT / LANE_W
) (
   input  lane_res_type  lane_res [NUM_LANES],
   input  logic          rise_ok,
   output merge_res_type merge_res
);

   logic                 pri_any;
   logic                 pend_any;
   logic [STATION_W-1:0] pri_station;
   logic [STATION_W-1:0] pend_station;

   // lowest lane wins for each candidate class
   always_comb begin
      pri_any      = 1'b0;
      pend_any     = 1'b0;
      pri_station  = '0;
      pend_station = '0;
      merge_res    = '0;
      for (int l = NUM_LANES - 1; l >= 0; l--) begin
         if (lane_res[l].fall_any) begin
            merge_res.fall_any = 1'b1;
         end
         if (lane_res[l].pri_hit) begin
            pri_any     = 1'b1;
            pri_station = (STATION_W'(l) << LANE_IDX_W) | STATION_W'(lane_res[l].pri_idx);
         end
         if (lane_res[l].pend_hit) begin
            pend_any     = 1'b1;
            pend_station = (STATION_W'(l) << LANE_IDX_W) | STATION_W'(lane_res[l].pend_idx);
         end
      end
      // priority channels first
      merge_res.rise = rise_ok && pend_any;
      if (merge_res.rise) begin
         merge_res.station = pri_any ? pri_station : pend_station;
      end
   end

endmodule

// File: rtl/staggered_output_rise_sequencer_top.sv
// ----------------------------------------------------------------------------
// staggered_output_rise_sequencer_top
// Output channel bitmap with staggered switch-on.
//
// req_chan carries one command transaction: advance (clear unwanted channels,
// raise at most one pending channel once the stagger interval has passed),
// restart the stagger timer, or clear it. rsp_chan returns exactly one
// transaction per request with the change flags, the raised channel and the
// bitmap after the step.
// The response is registered in the output stage before rsp_chan shows it.
// Throughput: one transaction per cycle while req_chan.ready is high; the lanes,
// the merge and the state update all settle in the accept cycle, so the bitmap
// feedback loop sets the rate.
// A two-entry output stage (register plus skid) lets a new request in while
// a response waits; req_chan.ready is low while both entries are full and
// rises the cycle after the receiver takes the older response.
// Reset (synchronous, active high) clears the bitmap and the stagger timer,
// sets active_stations to 64 and stagger_ms to 250, and empties the output stage.
// The csr port is to be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module staggered_output_rise_sequencer_top
   import sors_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   sors_stream_if.sink           req_chan,
   sors_stream_if.source         rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int NUM_LANES = (NUM_CHANNELS + LANE_W - 1) / LANE_W;
   localparam int PAD_W     = NUM_LANES * LANE_W;

   // state
   logic [ACT_W-1:0]        active_ff;
   logic [STAGGER_W-1:0]    stagger_ff;
   logic [NUM_CHANNELS-1:0] applied_ff,   applied_in;
   logic [TIME_W-1:0]       next_rise_ff, next_rise_in;
   logic                    timing_ff,    timing_in;

   // output stage
   logic            out_valid_ff,  out_valid_in;
   rsp_payload_type out_data_ff,   out_data_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_data_ff,  skid_data_in;

   req_payload_type req;
   rsp_payload_type rsp_new;
   logic            accept;
   logic            out_fire;
   logic            advance;

   logic [ACT_W-1:0]  active_eff;
   logic [PAD_W-1:0]  used_pad;
   logic [PAD_W-1:0]  applied_pad;
   logic [PAD_W-1:0]  desired_pad;
   logic [PAD_W-1:0]  priority_pad;
   logic [PAD_W-1:0]  kept_pad;
   logic [PAD_W-1:0]  result_pad;
   logic [TIME_W-1:0] time_diff;
   logic [TIME_W-1:0] rise_deadline;
   logic              rise_ok;
   lane_res_type      lane_res [NUM_LANES];
   merge_res_type     merge_res;

   // handshake
   assign req      = req_chan.payload;
   assign req_chan.ready = !skid_valid_ff;
   assign accept   = req_chan.valid && !skid_valid_ff;
   assign out_fire = out_valid_ff && rsp_chan.ready;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;
   assign advance  = (req.cmd == CMD_ADVANCE);

   // channels in use, saturated to the channel count
   assign active_eff = (active_ff > ACT_W'(NUM_CHANNELS)) ? ACT_W'(NUM_CHANNELS) : active_ff;

   genvar g;
   generate
      for (g = 0; g < PAD_W; g++) begin : g_used
         assign used_pad[g] = (ACT_W'(g) < active_eff);
      end
   endgenerate

   assign applied_pad  = PAD_W'(applied_ff);
   assign desired_pad  = PAD_W'(req.desired_bits[NUM_CHANNELS-1:0]);
   assign priority_pad = PAD_W'(req.priority_bits[NUM_CHANNELS-1:0]);

   // stagger interval check, wrap-safe
   assign time_diff     = req.now_ms - next_rise_ff;
   assign rise_ok       = req.rise_enable && !(timing_ff && time_diff[TIME_W-1]);
   assign rise_deadline = req.now_ms + TIME_W'(stagger_ff);

   // channel lanes
   generate
      for (g = 0; g < NUM_LANES; g++) begin : g_lane
         sors_lane u_lane (
            .applied_bits  (applied_pad[g*LANE_W +: LANE_W]),
            .desired_bits  (desired_pad[g*LANE_W +: LANE_W]),
            .priority_bits (priority_pad[g*LANE_W +: LANE_W]),
            .used_mask     (used_pad[g*LANE_W +: LANE_W]),
            .kept_bits     (kept_pad[g*LANE_W +: LANE_W]),
            .lane_res      (lane_res[g])
         );
      end
   endgenerate

   sors_merge #(
      .NUM_LANES (NUM_LANES)
   ) u_merge (
      .lane_res  (lane_res),
      .rise_ok   (rise_ok),
      .merge_res (merge_res)
   );

   assign result_pad = merge_res.rise ? (kept_pad | (PAD_W'(1) << merge_res.station)) : kept_pad;

   // next state and response
   always_comb begin
      applied_in   = applied_ff;
      next_rise_in = next_rise_ff;
      timing_in    = timing_ff;
      rsp_new      = '0;
      case (req.cmd)
         CMD_ADVANCE: begin
            applied_in = result_pad[NUM_CHANNELS-1:0];
            if (merge_res.rise) begin
               next_rise_in = rise_deadline;
               timing_in    = 1'b1;
            end
            rsp_new.changed        = merge_res.fall_any || merge_res.rise;
            rsp_new.rise_valid     = merge_res.rise;
            rsp_new.rising_station = merge_res.station;
         end
         CMD_RISE_DONE: begin
            next_rise_in = rise_deadline;
            timing_in    = 1'b1;
         end
         CMD_CLEAR_TIMING: begin
            next_rise_in = '0;
            timing_in    = 1'b0;
         end
         default: begin
         end
      endcase
      rsp_new.applied_out = MAP_W'(applied_in);
   end

   // output register and skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_fire) begin
            out_valid_in = 1'b1;
            out_data_in  = rsp_new;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = rsp_new;
         end
      end else if (out_fire) begin
         out_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         applied_ff    <= '0;
         next_rise_ff  <= '0;
         timing_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            applied_ff   <= applied_in;
            next_rise_ff <= next_rise_in;
            timing_ff    <= timing_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= ACTIVE_RESET;
         stagger_ff <= STAGGER_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ACTIVE_STATIONS: active_ff  <= csr_write_data[ACT_W-1:0];
            CSR_STAGGER_MS:      stagger_ff <= csr_write_data[STAGGER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef NO_ASSERTIONS
   // skid entry only fills behind a waiting response
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without output entry");

   // a raised channel was off before the step
   a_rise_was_off: assert property (@(posedge clock) disable iff (reset)
      (accept && advance && merge_res.rise) |-> !applied_pad[merge_res.station])
      else $error("raised channel already on");

   // a rise arms the stagger timer
   a_rise_arms_timer: assert property (@(posedge clock) disable iff (reset)
      (accept && advance && merge_res.rise) |=> timing_ff)
      else $error("rise did not arm stagger timer");

   // timer commands leave the bitmap alone
   a_timer_cmd_keeps_map: assert property (@(posedge clock) disable iff (reset)
      (accept && !advance) |=> (applied_ff == $past(applied_ff)))
      else $error("timer command changed the bitmap");
`endif

endmodule
